// ===== hdl/bdd_pkg.sv =====
package bdd_pkg;

    // Default sizes for the top level
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Request codes
    localparam logic [3:0] REQ_PUSH_FRONT  = 4'd0;
    localparam logic [3:0] REQ_PUSH_BACK   = 4'd1;
    localparam logic [3:0] REQ_POP_FRONT   = 4'd2;
    localparam logic [3:0] REQ_POP_BACK    = 4'd3;
    localparam logic [3:0] REQ_CLEAR       = 4'd4;
    localparam logic [3:0] REQ_DELETE      = 4'd5;
    localparam logic [3:0] REQ_PRINT_ALL   = 4'd6;
    localparam logic [3:0] REQ_PRINT_FIRST = 4'd7;
    localparam logic [3:0] REQ_PRINT_LAST  = 4'd8;

    // Result kinds
    localparam logic [1:0] KIND_ENTRY  = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] operand_value;
        logic [6:0]         print_count;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic signed [31:0] entry_value;
        logic               last_of_run;
    } rsp_item_t;

    // What every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHR,
        CELL_SHL,
        CELL_LOAD
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     wrap;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_WALK
    } state_t;

endpackage

// ===== hdl/bdd_cell.sv =====
module bdd_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int CELL_IDX   = 0
) (
    input  logic                    clk,
    input  bdd_pkg::cell_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]        sel_idx,
    input  logic [DATA_WIDTH-1:0]   push_data,
    input  logic [DATA_WIDTH-1:0]   front_data,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    output logic [DATA_WIDTH-1:0]   data_q
);
    import bdd_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  is_sel;

    assign is_sel = (sel_idx == MY_IDX);

    // Shift, rotate or load one word
    always_comb
    begin
        unique case (ctrl.op)
            CELL_HOLD: data_next = data_reg;
            CELL_SHR:  data_next = (CELL_IDX == 0) ? push_data : left_data;
            CELL_SHL:  data_next = (ctrl.wrap && is_sel) ? front_data : right_data;
            CELL_LOAD: data_next = is_sel ? push_data : data_reg;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_q = data_reg;

endmodule

// ===== hdl/bdd_ctrl.sv =====
module bdd_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         req_valid,
    output logic                                         req_stall,
    input  bdd_pkg::req_item_t                           req_item,
    output logic                                         rsp_valid,
    input  logic                                         rsp_stall,
    output bdd_pkg::rsp_item_t                           rsp_item,
    input  logic [DATA_WIDTH-1:0]                        front_data,
    output bdd_pkg::cell_ctrl_t                          cell_ctrl,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] sel_idx,
    output logic [DATA_WIDTH-1:0]                        push_data
);
    import bdd_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int MW    = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic [CNT_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic                  is_del_reg, is_del_next;
    logic                  found_reg, found_next;
    logic [DATA_WIDTH-1:0] del_val_reg, del_val_next;
    logic [1:0]            kind_reg, kind_next;
    logic                  out_valid_reg, out_valid_next;
    rsp_item_t             out_item_reg, out_item_next;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    rsp_item_t             out_load_item;
    logic [DATA_WIDTH-1:0] operand_w;
    logic                  is_full;
    logic                  is_empty;
    logic [CNT_W-1:0]      run_cnt;
    logic                  advance;
    logic                  drop;
    logic                  is_print;
    logic                  needs_single;
    logic                  starts_walk;
    logic                  walk_done;

    assign accept    = req_valid && (state_reg == ST_IDLE);
    assign req_stall = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign operand_w = DATA_WIDTH'(req_item.operand_value);
    assign is_full   = (occ_reg == FULL_CNT);
    assign is_empty  = (occ_reg == '0);
    assign is_print  = (req_item.req_type == REQ_PRINT_ALL)
                    || (req_item.req_type == REQ_PRINT_FIRST)
                    || (req_item.req_type == REQ_PRINT_LAST);

    // Entries in a print run, count clamped to the length
    always_comb
    begin
        if (req_item.req_type == REQ_PRINT_ALL)
            run_cnt = occ_reg;
        else if (MW'(req_item.print_count) < MW'(occ_reg))
            run_cnt = CNT_W'(req_item.print_count);
        else
            run_cnt = occ_reg;
    end

    assign needs_single = (((req_item.req_type == REQ_PUSH_FRONT)
                         || (req_item.req_type == REQ_PUSH_BACK)) && is_full)
                       || (is_print && (run_cnt == '0));
    assign starts_walk  = ((req_item.req_type == REQ_DELETE) && !is_empty)
                       || (is_print && (run_cnt != '0));

    assign advance   = is_del_reg || out_free;
    assign drop      = is_del_reg && !found_reg && (front_data == del_val_reg);
    assign walk_done = advance && (left_reg == ONE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && needs_single)
                    state_next = ST_SINGLE;
                else if (accept && starts_walk)
                    state_next = ST_WALK;
            end
            ST_SINGLE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_WALK:
            begin
                if (walk_done)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and cell commands
    always_comb
    begin
        occ_next       = occ_reg;
        left_next      = left_reg;
        step_next      = step_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        is_del_next    = is_del_reg;
        found_next     = found_reg;
        del_val_next   = del_val_reg;
        kind_next      = kind_reg;
        cell_ctrl.op   = CELL_HOLD;
        cell_ctrl.wrap = 1'b0;
        sel_idx        = IDX_W'(occ_reg);
        out_load       = 1'b0;
        out_load_item  = '{result_kind: KIND_ENTRY, entry_value: '0, last_of_run: 1'b1};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next    = is_print ? KIND_EMPTY : KIND_REJECT;
                    left_next    = occ_reg;
                    step_next    = '0;
                    found_next   = 1'b0;
                    del_val_next = operand_w;
                    is_del_next  = (req_item.req_type == REQ_DELETE);
                    lo_next      = (req_item.req_type == REQ_PRINT_LAST)
                                 ? (occ_reg - run_cnt) : '0;
                    hi_next      = ((req_item.req_type == REQ_PRINT_LAST)
                                 ? occ_reg : run_cnt) - ONE;
                    priority case (req_item.req_type)
                        REQ_PUSH_FRONT:
                        begin
                            if (!is_full)
                            begin
                                cell_ctrl.op = CELL_SHR;
                                occ_next     = occ_reg + ONE;
                            end
                        end
                        REQ_PUSH_BACK:
                        begin
                            if (!is_full)
                            begin
                                cell_ctrl.op = CELL_LOAD;
                                occ_next     = occ_reg + ONE;
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (!is_empty)
                            begin
                                cell_ctrl.op = CELL_SHL;
                                occ_next     = occ_reg - ONE;
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (!is_empty)
                                occ_next = occ_reg - ONE;
                        end
                        REQ_CLEAR:
                        begin
                            occ_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SINGLE:
            begin
                if (out_free)
                begin
                    out_load                  = 1'b1;
                    out_load_item.result_kind = kind_reg;
                end
            end
            ST_WALK:
            begin
                // Front entry leaves; it rotates to the tail or is dropped
                if (advance)
                begin
                    cell_ctrl.op = CELL_SHL;
                    sel_idx      = IDX_W'(occ_reg - ONE);
                    if (drop)
                    begin
                        occ_next   = occ_reg - ONE;
                        found_next = 1'b1;
                    end
                    else
                    begin
                        cell_ctrl.wrap = 1'b1;
                    end
                    left_next = left_reg - ONE;
                    step_next = step_reg + ONE;
                    if (!is_del_reg && (step_reg >= lo_reg) && (step_reg <= hi_reg))
                    begin
                        out_load                  = 1'b1;
                        out_load_item.result_kind = KIND_ENTRY;
                        out_load_item.entry_value = 32'(front_data);
                        out_load_item.last_of_run = (step_reg == hi_reg);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_item_next  = out_load_item;
        end
        else
        begin
            out_valid_next = out_valid_reg && rsp_stall;
            out_item_next  = out_item_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        step_reg     <= step_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        is_del_reg   <= is_del_next;
        found_reg    <= found_next;
        del_val_reg  <= del_val_next;
        kind_reg     <= kind_next;
        out_item_reg <= out_item_next;
    end

    assign push_data = operand_w;
    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

endmodule

// ===== hdl/bounded_deque_with_delete.sv =====
// Channel | Direction | Handshake              | Payload
// req     | in        | req_valid / req_stall  | req_item  (req_type, operand_value, print_count)
// rsp     | out       | rsp_valid / rsp_stall  | rsp_item  (result_kind, entry_value, last_of_run)
//
// Push, pop, clear and ignored codes are handled in the accepting cycle. Delete on a
// non-empty store and print of a non-empty run take the accepting cycle, then walk the
// chain of cells once, rotating one entry a cycle. A rejection or empty marker goes
// through a single state to the result register. A stalled result output pauses a
// print walk or a pending rejection or empty marker; a delete walk never waits.
// Reset clears the entry count and control only; cell contents are not cleared.
module bounded_deque_with_delete #(
    parameter int CAPACITY   = bdd_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = bdd_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bdd_pkg::req_item_t  req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bdd_pkg::rsp_item_t  rsp_item
);
    import bdd_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
    cell_ctrl_t            cell_ctrl;
    logic [IDX_W-1:0]      sel_idx;
    logic [DATA_WIDTH-1:0] push_data;

    // Sequencer and result register
    bdd_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item),
        .front_data (cell_q[0]),
        .cell_ctrl  (cell_ctrl),
        .sel_idx    (sel_idx),
        .push_data  (push_data)
    );

    // Row of storage cells, front at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = push_data;
        end
        else
        begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = cell_q[0];
        end
        else
        begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        bdd_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .sel_idx    (sel_idx),
            .push_data  (push_data),
            .front_data (cell_q[0]),
            .left_data  (left_w),
            .right_data (right_w),
            .data_q     (cell_q[i])
        );
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bdd_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_ITEMS    = 12;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int TAIL_CYCLES     = 2 * CAPACITY_DEF + 16;
    localparam int QUIET_LIMIT     = 4000;

    // Codes the block ignores
    localparam logic [3:0] REQ_UNUSED_FIRST = 4'd9;
    localparam logic [3:0] REQ_UNUSED_LAST  = 4'd15;

    // Mirror of the deque contents plus the results still owed by the block
    class deque_scoreboard;
        logic signed [31:0] entries[$];
        rsp_item_t          owed_results[$];
        int unsigned        error_count;

        function new();
            error_count = 0;
        endfunction

        task report_mismatch(input string what);
            error_count++;
            $display("[%0t] MISMATCH: %s", $time, what);
        endtask

        function void owe_single(input logic [1:0] kind);
            rsp_item_t r;
            r.result_kind = kind;
            r.entry_value = '0;
            r.last_of_run = 1'b1;
            owed_results.push_back(r);
        endfunction

        // Stream count entries starting at first; an empty run is one marker
        function void owe_run(input int first, input int count);
            rsp_item_t r;
            if (count == 0)
                owe_single(KIND_EMPTY);
            else
                for (int k = 0; k < count; k++)
                begin
                    r.result_kind = KIND_ENTRY;
                    r.entry_value = entries[first + k];
                    r.last_of_run = (k == count - 1);
                    owed_results.push_back(r);
                end
        endfunction

        // Apply one accepted request to the mirror
        function void note_request(input req_item_t req);
            int n;
            int hit;
            n = req.print_count;
            if (n > entries.size())
                n = entries.size();
            case (req.req_type)
                REQ_PUSH_FRONT:
                    if (entries.size() >= CAPACITY_DEF)
                        owe_single(KIND_REJECT);
                    else
                        entries.push_front(req.operand_value);
                REQ_PUSH_BACK:
                    if (entries.size() >= CAPACITY_DEF)
                        owe_single(KIND_REJECT);
                    else
                        entries.push_back(req.operand_value);
                REQ_POP_FRONT:
                    if (entries.size() > 0)
                        void'(entries.pop_front());
                REQ_POP_BACK:
                    if (entries.size() > 0)
                        void'(entries.pop_back());
                REQ_CLEAR:
                    entries.delete();
                REQ_DELETE:
                begin
                    hit = -1;
                    for (int i = 0; i < entries.size(); i++)
                        if (hit < 0 && entries[i] == req.operand_value)
                            hit = i;
                    if (hit >= 0)
                        entries.delete(hit);
                end
                REQ_PRINT_ALL:   owe_run(0, entries.size());
                REQ_PRINT_FIRST: owe_run(0, n);
                REQ_PRINT_LAST:  owe_run(entries.size() - n, n);
                default: ;
            endcase
        endfunction

        task check_result(input rsp_item_t got);
            rsp_item_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result kind %0d value %0d last %0b",
                                          got.result_kind, got.entry_value, got.last_of_run));
                return;
            end
            want = owed_results.pop_front();
            if (got.result_kind !== want.result_kind)
                report_mismatch($sformatf("result_kind got %0d want %0d",
                                          got.result_kind, want.result_kind));
            if (got.entry_value !== want.entry_value)
                report_mismatch($sformatf("entry_value got %0d want %0d",
                                          got.entry_value, want.entry_value));
            if (got.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run got %0b want %0b",
                                          got.last_of_run, want.last_of_run));
        endtask

        function int owed_count();
            return owed_results.size();
        endfunction

        function logic signed [31:0] pick_stored_value();
            if (entries.size() == 0)
                return $signed(32'($urandom_range(0, 7))) - 32'sd3;
            return entries[$urandom_range(0, entries.size() - 1)];
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    req_item_t req_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    deque_scoreboard sb;
    int burst_left    = 1;
    int hold_requests = 0;
    int hold_served   = 0;
    int quiet_cycles  = 0;

    bounded_deque_with_delete u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    always #CLK_HALF clk = ~clk;

    // Monitor both channels and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req_item);
            if (rsp_valid && !rsp_stall)
                sb.check_result(rsp_item);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver: shifting stall patterns, plus a long hold-off on request
    initial
    begin
        int seg_left;
        int mode;
        seg_left = 0;
        mode     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served++;
                rsp_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(16, 96);
            end
            seg_left--;
            case (mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 3) == 0);
                2:       rsp_stall <= ($urandom_range(0, 9) < 6);
                default: rsp_stall <= (seg_left % 3 == 0);
            endcase
        end
    end

    function req_item_t make_req(input logic [3:0] kind, input logic signed [31:0] value,
                                 input logic [6:0] count);
        req_item_t r;
        r.req_type      = kind;
        r.operand_value = value;
        r.print_count   = count;
        return r;
    endfunction

    // Small values give duplicates for delete; the rest span the full word
    function logic signed [31:0] rand_word();
        if ($urandom_range(0, 1) == 0)
            return $signed(32'($urandom_range(0, 7))) - 32'sd3;
        return $signed($urandom);
    endfunction

    function req_item_t random_request();
        int pick;
        logic [3:0] kind;
        logic signed [31:0] value;
        logic [6:0] count;
        pick  = $urandom_range(0, 99);
        value = rand_word();
        count = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 70));
        if (pick < 22)      kind = REQ_PUSH_FRONT;
        else if (pick < 44) kind = REQ_PUSH_BACK;
        else if (pick < 52) kind = REQ_POP_FRONT;
        else if (pick < 58) kind = REQ_POP_BACK;
        else if (pick < 60) kind = REQ_CLEAR;
        else if (pick < 72) kind = REQ_DELETE;
        else if (pick < 80) kind = REQ_PRINT_ALL;
        else if (pick < 88) kind = REQ_PRINT_FIRST;
        else if (pick < 96) kind = REQ_PRINT_LAST;
        else                kind = 4'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        if (kind == REQ_DELETE && $urandom_range(0, 9) < 6)
            value = sb.pick_stored_value();
        return make_req(kind, value, count);
    endfunction

    // Offer one item, hold it until taken, then maybe drop valid for a gap
    task offer_request(input req_item_t item);
        int gap;
        req_valid <= 1'b1;
        req_item  <= item;
        do
            @(posedge clk);
        while (req_stall);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop offering until every owed result has come back
    task wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed_count() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int fill_count;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, field extremes, clamps, misses, ignored codes
        offer_request(make_req(REQ_PRINT_ALL,   32'sd0, 7'd0));
        offer_request(make_req(REQ_PRINT_FIRST, 32'sd0, 7'd5));
        offer_request(make_req(REQ_POP_FRONT,   32'sd0, 7'd0));
        offer_request(make_req(REQ_POP_BACK,    32'sd0, 7'd0));
        offer_request(make_req(REQ_DELETE,      32'sd0, 7'd0));
        offer_request(make_req(REQ_PUSH_FRONT,  32'sh7fffffff, 7'd0));
        offer_request(make_req(REQ_PUSH_BACK,   32'sh80000000, 7'd127));
        offer_request(make_req(REQ_PUSH_FRONT,  -32'sd1, 7'd0));
        offer_request(make_req(REQ_PUSH_BACK,   32'sd0, 7'd0));
        offer_request(make_req(REQ_PUSH_BACK,   32'sd7, 7'd0));
        offer_request(make_req(REQ_PRINT_ALL,   32'sd0, 7'd0));
        offer_request(make_req(REQ_PRINT_FIRST, 32'sd0, 7'd0));
        offer_request(make_req(REQ_PRINT_FIRST, 32'sd0, 7'd2));
        offer_request(make_req(REQ_PRINT_FIRST, 32'sd0, 7'd127));
        offer_request(make_req(REQ_PRINT_LAST,  32'sd0, 7'd1));
        offer_request(make_req(REQ_PRINT_LAST,  32'sd0, 7'd64));
        offer_request(make_req(REQ_PRINT_LAST,  32'sd0, 7'd0));
        offer_request(make_req(REQ_DELETE,      32'sd12345, 7'd0));
        offer_request(make_req(REQ_DELETE,      -32'sd1, 7'd0));
        offer_request(make_req(REQ_POP_FRONT,   32'sd0, 7'd0));
        offer_request(make_req(REQ_POP_BACK,    32'sd0, 7'd0));
        offer_request(make_req(REQ_UNUSED_FIRST, 32'sd0, 7'd0));
        offer_request(make_req(REQ_UNUSED_LAST, -32'sd1, 7'd127));
        offer_request(make_req(REQ_PRINT_ALL,   32'sd0, 7'd0));
        offer_request(make_req(REQ_CLEAR,       32'sd0, 7'd0));
        offer_request(make_req(REQ_PRINT_LAST,  32'sd0, 7'd3));
        wait_drained();

        // Fill the store to capacity with random words
        fill_count = CAPACITY_DEF - sb.entries.size();
        repeat (fill_count)
            offer_request(make_req($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                                   rand_word(), 7'($urandom_range(0, 127))));
        wait_drained();

        // Full store under a long receiver hold-off: rejects and long runs back up
        hold_requests++;
        offer_request(make_req(REQ_PUSH_FRONT,  rand_word(), 7'd0));
        offer_request(make_req(REQ_PUSH_BACK,   rand_word(), 7'd0));
        offer_request(make_req(REQ_PRINT_ALL,   32'sd0, 7'd0));
        offer_request(make_req(REQ_PRINT_FIRST, 32'sd0, 7'd127));
        offer_request(make_req(REQ_PRINT_LAST,  32'sd0, 7'd64));
        offer_request(make_req(REQ_DELETE,      sb.pick_stored_value(), 7'd0));
        offer_request(make_req(REQ_PRINT_LAST,  32'sd0, 7'd3));
        offer_request(make_req(REQ_POP_FRONT,   32'sd0, 7'd0));
        wait_drained();

        // Random traffic, with one full drain halfway
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            offer_request(random_request());
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
        end
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.owed_count() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.owed_count()));
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
